FILE: src/pcbn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_pkg
// shared constants and types of the per-class box nms core
// ----------------------------------------------------------------------------
package pcbn_pkg;

  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);
  localparam int EDGE_W    = 16;
  localparam int COORD_W   = 4 * EDGE_W;
  localparam int SCORE_W   = 16;
  localparam int CLASS_W   = 7;
  localparam int SC_W      = SCORE_W + CLASS_W;
  localparam int THR_W     = 17;
  localparam int PADDR_W   = 3;

  localparam logic [THR_W-1:0] THR_RESET = 17'd32768;
  localparam logic             REG_THR   = 1'b0;

  // result of the overlap unit
  typedef struct packed {
    logic done;
    logic hit;
  } iou_res_t;

endpackage

FILE: src/pcbn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pcbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/pcbn_iou.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbn_iou
// multi-cycle overlap test: intersection * 65536 > threshold * union
// ----------------------------------------------------------------------------
module pcbn_iou (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pcbn_pkg::COORD_W-1:0] box_a_i,
  input  logic [pcbn_pkg::COORD_W-1:0] box_b_i,
  input  logic [pcbn_pkg::THR_W-1:0]   thr_i,
  output pcbn_pkg::iou_res_t        res_o
);
  import pcbn_pkg::*;

  logic [COORD_W-1:0] a_q, b_q;
  logic [6:0]         stg_q;

  logic [EDGE_W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  logic [EDGE_W-1:0] left, right, top, bottom;

  logic              disj_q;
  logic [EDGE_W-1:0] iw_q, ih_q;
  logic signed [16:0] aw_q, ah_q, bw_q, bh_q;
  logic [31:0]        inter_q;
  logic signed [33:0] area_a_q, area_b_q;
  logic signed [35:0] uni_q;
  logic [34:0]        p_lo_q;
  logic signed [35:0] p_hi_q;
  logic signed [53:0] lhs, rhs;

  assign ax0 = a_q[15:0];  assign ay0 = a_q[31:16];
  assign ax1 = a_q[47:32]; assign ay1 = a_q[63:48];
  assign bx0 = b_q[15:0];  assign by0 = b_q[31:16];
  assign bx1 = b_q[47:32]; assign by1 = b_q[63:48];

  assign left   = (ax0 > bx0) ? ax0 : bx0;
  assign right  = (ax1 < bx1) ? ax1 : bx1;
  assign top    = (ay0 > by0) ? ay0 : by0;
  assign bottom = (ay1 < by1) ? ay1 : by1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else begin
      stg_q <= {stg_q[5:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= box_a_i;
      b_q <= box_b_i;
    end
    if (stg_q[0]) begin
      disj_q <= (top > bottom) || (left > right);
      iw_q   <= right - left;
      ih_q   <= bottom - top;
      aw_q   <= $signed({1'b0, ax1}) - $signed({1'b0, ax0});
      ah_q   <= $signed({1'b0, ay1}) - $signed({1'b0, ay0});
      bw_q   <= $signed({1'b0, bx1}) - $signed({1'b0, bx0});
      bh_q   <= $signed({1'b0, by1}) - $signed({1'b0, by0});
    end
    if (stg_q[1]) begin
      inter_q  <= iw_q * ih_q;
      area_a_q <= aw_q * ah_q;
    end
    if (stg_q[2]) begin
      area_b_q <= bw_q * bh_q;
    end
    if (stg_q[3]) begin
      uni_q <= 36'(area_a_q) + 36'(area_b_q) - $signed({4'b0, inter_q});
    end
    // threshold times union in two partial products
    if (stg_q[4]) begin
      p_lo_q <= thr_i * uni_q[17:0];
    end
    if (stg_q[5]) begin
      p_hi_q <= $signed({1'b0, thr_i}) * $signed(uni_q[35:18]);
    end
  end

  assign lhs = $signed({6'b0, inter_q, 16'b0});
  assign rhs = (54'(p_hi_q) <<< 18) + $signed({19'b0, p_lo_q});

  assign res_o.done = stg_q[6];
  assign res_o.hit  = !disj_q && (lhs > rhs);

endmodule

FILE: src/per_class_box_nms_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_class_box_nms_core
// per-class greedy non-maximum suppression over a set of up to 64 boxes
// ----------------------------------------------------------------------------
// a box that does not close the set is taken with busy staying low
// closing the set: rank sort of the n boxes; suppressed boxes are skipped, each
//   kept box is loaded and each later partner skipped if suppressed, read and
//   passed if of another class, overlap-tested if of the same; then back to idle
// throughput: one set at a time; kept words leave one per strobe, no stall
// reset clears counts, marks, overflow flag and threshold (0.5); rams not reset
module per_class_box_nms_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command side
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [pcbn_pkg::EDGE_W-1:0]    box_x0_i,
  input  logic [pcbn_pkg::EDGE_W-1:0]    box_y0_i,
  input  logic [pcbn_pkg::EDGE_W-1:0]    box_x1_i,
  input  logic [pcbn_pkg::EDGE_W-1:0]    box_y1_i,
  input  logic [pcbn_pkg::SCORE_W-1:0]   score_i,
  input  logic [pcbn_pkg::CLASS_W-1:0]   class_index_i,
  input  logic                           set_last_i,
  // result side
  output logic                           kept_valid_o,
  output logic [pcbn_pkg::EDGE_W-1:0]    kept_x0_o,
  output logic [pcbn_pkg::EDGE_W-1:0]    kept_y0_o,
  output logic [pcbn_pkg::EDGE_W-1:0]    kept_x1_o,
  output logic [pcbn_pkg::EDGE_W-1:0]    kept_y1_o,
  output logic [pcbn_pkg::SCORE_W-1:0]   kept_score_o,
  output logic [pcbn_pkg::CLASS_W-1:0]   kept_class_o,
  output logic                           overflowed_o,
  output logic                           run_last_o,
  // apb config
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcbn_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import pcbn_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] SR_RDI    = 4'd1;
  localparam logic [3:0] SR_LATI   = 4'd2;
  localparam logic [3:0] SR_SCAN   = 4'd3;
  localparam logic [3:0] SR_WR     = 4'd4;
  localparam logic [3:0] SP_CHK    = 4'd5;
  localparam logic [3:0] SP_ORD    = 4'd6;
  localparam logic [3:0] SP_LATI   = 4'd7;
  localparam logic [3:0] SP_J      = 4'd8;
  localparam logic [3:0] SP_JORD   = 4'd9;
  localparam logic [3:0] SP_JLAT   = 4'd10;
  localparam logic [3:0] SP_WAIT   = 4'd11;

  logic [3:0]           state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [MAX_BOXES-1:0] supp_q, supp_d;
  logic [CNT_W-1:0]     i_q, i_d, j_q, j_d, rank_q, rank_d;
  logic [THR_W-1:0]     thr_q;
  logic [SC_W-1:0]      key_q, key_d;
  logic [COORD_W-1:0]   cur_coord_q, cur_coord_d;
  logic [SC_W-1:0]      cur_sc_q, cur_sc_d;
  logic                 valid_q, valid_d, rl_q, rl_d;

  // ram ports
  logic               box_we;
  logic [IDX_W-1:0]   box_raddr;
  logic [COORD_W-1:0] coord_rdata;
  logic [SC_W-1:0]    sc_rdata;
  logic               ord_we;
  logic [IDX_W-1:0]   ord_raddr;
  logic [IDX_W-1:0]   ord_rdata;

  logic     iou_start;
  iou_res_t iou_res;

  logic accept, jp_first, later_kept;
  logic [CNT_W-1:0] jp;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);
  assign box_we = accept && (cnt_q < CNT_W'(MAX_BOXES));

  pcbn_ram #(.WIDTH(COORD_W), .DEPTH(MAX_BOXES)) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (box_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i ({box_y1_i, box_x1_i, box_y0_i, box_x0_i}),
    .raddr_i (box_raddr),
    .rdata_o (coord_rdata)
  );

  pcbn_ram #(.WIDTH(SC_W), .DEPTH(MAX_BOXES)) u_sc_ram (
    .clk_i   (clk_i),
    .we_i    (box_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i ({class_index_i, score_i}),
    .raddr_i (box_raddr),
    .rdata_o (sc_rdata)
  );

  // sorted order: position -> box slot
  pcbn_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BOXES)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (rank_q[IDX_W-1:0]),
    .wdata_i (i_q[IDX_W-1:0]),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  pcbn_iou u_iou (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (iou_start),
    .box_a_i (cur_coord_q),
    .box_b_i (coord_rdata),
    .thr_i   (thr_q),
    .res_o   (iou_res)
  );

  // read address selection
  always_comb begin
    case (state_q)
      SR_RDI:           box_raddr = i_q[IDX_W-1:0];
      SR_LATI, SR_SCAN: box_raddr = j_q[IDX_W-1:0];
      SP_ORD, SP_JORD:  box_raddr = ord_rdata;
      default:          box_raddr = '0;
    endcase
    case (state_q)
      SP_CHK:  ord_raddr = i_q[IDX_W-1:0];
      SP_J:    ord_raddr = j_q[IDX_W-1:0];
      default: ord_raddr = '0;
    endcase
  end

  assign ord_we    = (state_q == SR_WR);
  assign iou_start = (state_q == SP_JLAT) && (sc_rdata[SC_W-1:SCORE_W] ==
                                               cur_sc_q[SC_W-1:SCORE_W]);

  // entry jp goes ahead of entry i: lower class, higher score, or arrived earlier
  assign jp = j_q - CNT_W'(1);
  always_comb begin
    logic [CLASS_W-1:0] cj, ci;
    logic [SCORE_W-1:0] sj, si;
    cj = sc_rdata[SC_W-1:SCORE_W];
    ci = key_q[SC_W-1:SCORE_W];
    sj = sc_rdata[SCORE_W-1:0];
    si = key_q[SCORE_W-1:0];
    if (cj != ci) begin
      jp_first = (cj < ci);
    end else if (sj != si) begin
      jp_first = (sj > si);
    end else begin
      jp_first = (jp < i_q);
    end
  end

  // if any box after position i is still unsuppressed, at least one more box is kept
  always_comb begin
    later_kept = 1'b0;
    for (int k = 0; k < MAX_BOXES; k++) begin
      if (!supp_q[k] && (CNT_W'(k) > i_q) && (CNT_W'(k) < cnt_q)) begin
        later_kept = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    supp_d      = supp_q;
    i_d         = i_q;
    j_d         = j_q;
    rank_d      = rank_q;
    key_d       = key_q;
    cur_coord_d = cur_coord_q;
    cur_sc_d    = cur_sc_q;
    valid_d     = 1'b0;
    rl_d        = rl_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (box_we) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (set_last_i) begin
            i_d     = '0;
            state_d = SR_RDI;
          end
        end
      end
      SR_RDI: begin
        j_d     = '0;
        state_d = SR_LATI;
      end
      SR_LATI: begin
        key_d   = sc_rdata;
        rank_d  = '0;
        j_d     = CNT_W'(1);
        state_d = SR_SCAN;
      end
      SR_SCAN: begin
        if (jp_first) begin
          rank_d = rank_q + CNT_W'(1);
        end
        if (j_q == cnt_q) begin
          state_d = SR_WR;
        end else begin
          j_d = j_q + CNT_W'(1);
        end
      end
      SR_WR: begin
        if (i_q + CNT_W'(1) == cnt_q) begin
          i_d     = '0;
          supp_d  = '0;
          state_d = SP_CHK;
        end else begin
          i_d     = i_q + CNT_W'(1);
          state_d = SR_RDI;
        end
      end
      SP_CHK: begin
        if (i_q == cnt_q) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          supp_d  = '0;
          state_d = ST_IDLE;
        end else if (supp_q[i_q[IDX_W-1:0]]) begin
          i_d = i_q + CNT_W'(1);
        end else begin
          state_d = SP_ORD;
        end
      end
      SP_ORD: begin
        state_d = SP_LATI;
      end
      SP_LATI: begin
        cur_coord_d = coord_rdata;
        cur_sc_d    = sc_rdata;
        j_d         = i_q + CNT_W'(1);
        state_d     = SP_J;
      end
      SP_J: begin
        if (j_q == cnt_q) begin
          valid_d = 1'b1;
          rl_d    = !later_kept;
          i_d     = i_q + CNT_W'(1);
          state_d = SP_CHK;
        end else if (supp_q[j_q[IDX_W-1:0]]) begin
          j_d = j_q + CNT_W'(1);
        end else begin
          state_d = SP_JORD;
        end
      end
      SP_JORD: begin
        state_d = SP_JLAT;
      end
      SP_JLAT: begin
        if (iou_start) begin
          state_d = SP_WAIT;
        end else begin
          j_d     = j_q + CNT_W'(1);
          state_d = SP_J;
        end
      end
      SP_WAIT: begin
        if (iou_res.done) begin
          if (iou_res.hit) begin
            supp_d[j_q[IDX_W-1:0]] = 1'b1;
          end
          j_d     = j_q + CNT_W'(1);
          state_d = SP_J;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      supp_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      rank_q  <= '0;
      valid_q <= 1'b0;
      rl_q    <= 1'b0;
      thr_q   <= THR_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      supp_q  <= supp_d;
      i_q     <= i_d;
      j_q     <= j_d;
      rank_q  <= rank_d;
      valid_q <= valid_d;
      rl_q    <= rl_d;
      if (psel && penable && pwrite && (paddr[2] == REG_THR)) begin
        thr_q <= pwdata[THR_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    cur_coord_q <= cur_coord_d;
    cur_sc_q    <= cur_sc_d;
  end

  // kept word comes straight from the current-box registers
  assign kept_valid_o = valid_q;
  assign kept_x0_o    = cur_coord_q[15:0];
  assign kept_y0_o    = cur_coord_q[31:16];
  assign kept_x1_o    = cur_coord_q[47:32];
  assign kept_y1_o    = cur_coord_q[63:48];
  assign kept_score_o = cur_sc_q[SCORE_W-1:0];
  assign kept_class_o = cur_sc_q[SC_W-1:SCORE_W];
  assign overflowed_o = ovf_q;
  assign run_last_o   = rl_q;

  assign prdata = (paddr[2] == REG_THR) ? {{(32-THR_W){1'b0}}, thr_q} : 32'd0;
  assign pready = 1'b1;

`ifndef ASSERT_OFF
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_valid_o |=> !kept_valid_o) else $error("kept strobe longer than one cycle");
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_valid_o |-> busy_o) else $error("kept word outside a set run");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_BOXES)) else $error("box count beyond capacity");
  a_iou_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iou_res.done |-> (state_q == SP_WAIT)) else $error("overlap result unexpected");
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (supp_q == '0)) else $error("marks left after set");
`endif

endmodule

FILE: dv/per_class_box_nms_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_class_box_nms_core_test
// self-checking bench: loads box sets, predicts the kept boxes of per-class
// greedy suppression and compares every kept word against the prediction
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [15:0] x0, y0, x1, y1;
  logic [15:0] score;
  logic [6:0]  cls;
  logic        ovf;
  logic        last;
} kept_word_t;

typedef struct packed {
  logic [15:0] x0, y0, x1, y1;
  logic [15:0] score;
  logic [6:0]  cls;
} box_t;

class nms_scoreboard;
  box_t        boxes[64];
  int          nbox;
  bit          dropped;
  logic [16:0] thr;
  kept_word_t  pending[$];
  int          mismatches;

  function new();
    nbox = 0; dropped = 0; thr = 17'd32768; mismatches = 0;
  endfunction

  function bit too_close(box_t a, box_t b);
    longint l, r, t, bt, inter, uni;
    l = (a.x0 > b.x0) ? a.x0 : b.x0;
    r = (a.x1 < b.x1) ? a.x1 : b.x1;
    t = (a.y0 > b.y0) ? a.y0 : b.y0;
    bt = (a.y1 < b.y1) ? a.y1 : b.y1;
    if (t > bt || l > r) return 0;
    inter = (r - l) * (bt - t);
    uni = (longint'(a.x1) - a.x0) * (longint'(a.y1) - a.y0)
        + (longint'(b.x1) - b.x0) * (longint'(b.y1) - b.y0) - inter;
    return inter * 65536 > longint'(thr) * uni;
  endfunction

  // note one accepted box; closing the set fills the pending kept words
  function void note_box(box_t b, bit last);
    int order[64];
    bit gone[64];
    int i, j, cur, nk;
    kept_word_t w;
    if (nbox < 64) begin
      boxes[nbox] = b; nbox++;
    end else dropped = 1;
    if (!last) return;
    for (i = 0; i < nbox; i++) begin
      j = i;
      while (j > 0 && ((boxes[i].cls < boxes[order[j-1]].cls) ||
             (boxes[i].cls == boxes[order[j-1]].cls &&
              boxes[i].score > boxes[order[j-1]].score))) begin
        order[j] = order[j-1]; j--;
      end
      order[j] = i;
    end
    for (i = 0; i < 64; i++) gone[i] = 0;
    nk = 0;
    for (i = 0; i < nbox; i++) begin
      if (gone[i]) continue;
      cur = order[i];
      for (j = i + 1; j < nbox; j++)
        if (!gone[j] && boxes[order[j]].cls == boxes[cur].cls &&
            too_close(boxes[cur], boxes[order[j]]))
          gone[j] = 1;
      w = '{boxes[cur].x0, boxes[cur].y0, boxes[cur].x1, boxes[cur].y1,
            boxes[cur].score, boxes[cur].cls, dropped, 1'b0};
      pending = {pending, w};
      nk++;
    end
    if (nk > 0) pending[pending.size()-1].last = 1;
    nbox = 0; dropped = 0;
  endfunction

  function void check_word(kept_word_t got);
    kept_word_t exp;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected kept word %h", got);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10) $display("kept word mismatch: exp %h got %h", exp, got);
    end
  endfunction
endclass

module per_class_box_nms_core_test;
  import pcbn_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic start_i = 0, busy_o;
  logic [15:0] box_x0_i = 0, box_y0_i = 0, box_x1_i = 0, box_y1_i = 0, score_i = 0;
  logic [6:0] class_index_i = 0;
  logic set_last_i = 0;
  logic kept_valid_o;
  logic [15:0] kept_x0_o, kept_y0_o, kept_x1_o, kept_y1_o, kept_score_o;
  logic [6:0] kept_class_o;
  logic overflowed_o, run_last_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;

  nms_scoreboard board = new();
  bit quiet;  // no idle gaps while set

  per_class_box_nms_core dut (.*);

  always #10 clk_i = ~clk_i;

  // kept words are sampled at the edge that ends their strobe cycle
  always @(posedge clk_i)
    if (rst_ni && kept_valid_o)
      board.check_word('{kept_x0_o, kept_y0_o, kept_x1_o, kept_y1_o,
                         kept_score_o, kept_class_o, overflowed_o, run_last_o});

  // apb write: setup then access cycle, only while idle
  task write_thr(logic [16:0] v);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {REG_THR, 2'b00}; pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.thr = v;
  endtask

  // issue one box, held until accepted (start high, busy low at the edge)
  task send_box(box_t b, bit last);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      start_i <= 0;
      @(posedge clk_i);
    end
    start_i <= 1;
    {box_x0_i, box_y0_i, box_x1_i, box_y1_i, score_i, class_index_i} <= b;
    set_last_i <= last;
    do @(posedge clk_i); while (busy_o);
    board.note_box(b, last);
  endtask

  // wait for the set to drain before touching the threshold
  task drain();
    int guard;
    guard = 0;
    start_i <= 0;
    while ((board.pending.size() != 0 || busy_o) && guard < 2000000) begin
      @(posedge clk_i); guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  function box_t rand_box(int cls_span, bit clustered);
    box_t b;
    logic [15:0] bx, by;
    if (clustered) begin
      bx = 16'($urandom_range(0, 800)); by = 16'($urandom_range(0, 800));
      b.x0 = 16'(bx + $urandom_range(0, 40)); b.y0 = 16'(by + $urandom_range(0, 40));
      b.x1 = 16'(b.x0 + $urandom_range(0, 300)); b.y1 = 16'(b.y0 + $urandom_range(0, 300));
      if ($urandom_range(0, 19) == 0) b.x1 = 16'(b.x0 - $urandom_range(1, 50));
    end else begin
      b.x0 = 16'($urandom); b.y0 = 16'($urandom);
      b.x1 = 16'($urandom); b.y1 = 16'($urandom);
    end
    b.score = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    b.cls = 7'($urandom_range(0, cls_span));
    if ($urandom_range(0, 9) == 0) b.cls = 7'($urandom);
    return b;
  endfunction

  initial begin
    box_t b;
    int sent, n, k, ph;
    logic [16:0] thr_list[5] = '{17'd0, 17'd65536, 17'd131071, 17'd32768, 17'd19661};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: identical boxes, disjoint, touching, degenerate, extremes
    b = '{16'd0, 16'd0, 16'd100, 16'd100, 16'hFFFF, 7'd0};
    send_box(b, 0);
    b.score = 16'hFFFF; send_box(b, 0);             // equal score tie
    b = '{16'd200, 16'd200, 16'd300, 16'd300, 16'd5, 7'd0};
    send_box(b, 0);                                 // disjoint
    b = '{16'd100, 16'd0, 16'd150, 16'd100, 16'd7, 7'd0};
    send_box(b, 0);                                 // touching edge
    b = '{16'd50, 16'd50, 16'd10, 16'd10, 16'd9, 7'd0};
    send_box(b, 0);                                 // degenerate
    b = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 7'd127};
    send_box(b, 0);
    b = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 7'd127};
    send_box(b, 1);
    drain();
    b = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd10, 7'd3};
    send_box(b, 1);                                 // single box set
    drain();

    // overflow: 66 boxes, the last two dropped; the last one still closes the set
    write_thr(17'd0);
    for (k = 0; k < 66; k++) begin
      b = rand_box(2, 1);
      send_box(b, k == 65);
    end
    drain();

    sent = 0; ph = 0;
    while (sent < 290) begin
      write_thr(thr_list[ph % 5]);
      quiet = (ph == 2);
      for (k = 0; k < 4 && sent < 290; k++) begin
        n = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 12);
        for (int m = 0; m < n; m++) begin
          b = rand_box((ph % 2) ? 1 : 5, $urandom_range(0, 9) != 0);
          send_box(b, m == n - 1);
          sent++;
        end
      end
      drain();
      ph++;
    end
    quiet = 0;
    drain();

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("per_class_box_nms_core_test: clean");
    end else begin
      $display("per_class_box_nms_core_test: errors");
    end
    $finish;
  end

  initial begin
    #2000000000;
    $display("per_class_box_nms_core_test: errors");
    $finish;
  end
endmodule

FILE: per_class_box_nms_core.f
src/pcbn_pkg.sv
src/pcbn_ram.sv
src/pcbn_iou.sv
src/per_class_box_nms_core.sv
dv/per_class_box_nms_core_test.sv
